### sv/deq_pkg.sv
package deq_pkg;

  localparam int unsigned DepthDefault = 16;
  localparam int unsigned ValueW       = 32;
  localparam int unsigned OccW         = 5;
  localparam int unsigned FuncW        = 2;
  localparam int unsigned StatusW      = 2;
  localparam int unsigned OutDataW     = 40;

  typedef enum logic [FuncW-1:0] {
    FUNC_PUSH_FRONT = 2'd0,
    FUNC_PUSH_REAR  = 2'd1,
    FUNC_POP_FRONT  = 2'd2,
    FUNC_POP_REAR   = 2'd3
  } func_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNDERFLOW = 2'd1,
    STATUS_OVERFLOW  = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_e;

  localparam logic [ValueW-1:0] PopEmptyValue = '1;

endpackage

### sv/deq_ram.sv
module deq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

### sv/double_ended_queue.sv
// Double-ended queue over a ring buffer in one synchronous RAM.
// Push: result registered in the cycle after the transfer; next item needs a free output.
// Pop: RAM read data is registered, then loaded into the output register; no new item is
// taken in ST_READ. Underflow and overflow results load in the cycle after the transfer.
// Reset (rst_ni low, async) empties the queue; RAM contents are not cleared.
module double_ended_queue #(
  parameter int unsigned Depth = deq_pkg::DepthDefault,
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [deq_pkg::ValueW-1:0]    s_axis_tdata,   // value
  input  logic [deq_pkg::FuncW-1:0]     s_axis_tuser,   // func
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [deq_pkg::OutDataW-1:0]  m_axis_tdata,   // popped, occupancy, zero pad
  output logic [deq_pkg::StatusW-1:0]   m_axis_tuser    // status
);

  localparam logic [CntW-1:0] CntFull = CntW'(Depth);
  localparam logic [PtrW:0]   DepthW  = (PtrW + 1)'(Depth);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  deq_pkg::state_e state_q, state_d;
  logic [PtrW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;

  logic                          out_valid_q;
  logic [deq_pkg::ValueW-1:0]    popped_q, popped_d;
  deq_pkg::status_e              status_q, status_d;
  logic [deq_pkg::OccW-1:0]      occ_q;

  deq_pkg::func_e func;
  logic in_xfer, out_free, full, empty, load_now, load_read;
  logic we, re;
  logic [PtrW-1:0] waddr, raddr;
  logic [PtrW:0] rear_sum, rear_slot, last_sum, last_slot, next_sum;
  logic [PtrW-1:0] head_next;
  logic [deq_pkg::ValueW-1:0] rdata;
  logic [31:0] count_ext;

  assign func     = deq_pkg::func_e'(s_axis_tuser);
  assign out_free = !out_valid_q || m_axis_tready;
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign full     = (count_q == CntFull);
  assign empty    = (count_q == '0);

  // Ring slot arithmetic with explicit wrap
  assign rear_sum  = (PtrW + 1)'(head_q) + (PtrW + 1)'(count_q);
  assign rear_slot = (rear_sum >= DepthW) ? rear_sum - DepthW : rear_sum;
  assign last_sum  = (PtrW + 1)'(head_q) + (PtrW + 1)'(count_q - CntW'(1));
  assign last_slot = (last_sum >= DepthW) ? last_sum - DepthW : last_sum;
  assign next_sum  = (PtrW + 1)'(head_q) + (PtrW + 1)'(1);
  assign head_next = (next_sum >= DepthW) ? PtrW'(next_sum - DepthW) : PtrW'(next_sum);

  always_comb begin
    state_d = state_q;
    case (state_q)
      deq_pkg::ST_IDLE: begin
        if (in_xfer && func[1] && !empty) begin
          state_d = deq_pkg::ST_READ;
        end
      end
      deq_pkg::ST_READ: state_d = deq_pkg::ST_IDLE;
      default:          state_d = deq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    load_read     = 1'b0;
    case (state_q)
      deq_pkg::ST_IDLE: s_axis_tready = out_free;
      deq_pkg::ST_READ: load_read     = 1'b1;
      default:          s_axis_tready = 1'b0;
    endcase
  end

  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = head_q;
    raddr    = head_q;
    load_now = 1'b0;
    popped_d = '0;
    status_d = deq_pkg::STATUS_OK;
    if (in_xfer) begin
      case (func)
        deq_pkg::FUNC_PUSH_FRONT, deq_pkg::FUNC_PUSH_REAR: begin
          load_now = 1'b1;
          if (full) begin
            status_d = deq_pkg::STATUS_OVERFLOW;
          end else begin
            we      = 1'b1;
            count_d = count_q + CntW'(1);
            if (func == deq_pkg::FUNC_PUSH_FRONT) begin
              head_d = (head_q == '0) ? PtrLast : head_q - PtrW'(1);
              waddr  = head_d;
            end else begin
              waddr = PtrW'(rear_slot);
            end
          end
        end
        default: begin
          if (empty) begin
            load_now = 1'b1;
            popped_d = deq_pkg::PopEmptyValue;
            status_d = deq_pkg::STATUS_UNDERFLOW;
          end else begin
            re      = 1'b1;
            count_d = count_q - CntW'(1);
            if (func == deq_pkg::FUNC_POP_FRONT) begin
              raddr  = head_q;
              head_d = head_next;
            end else begin
              raddr = PtrW'(last_slot);
            end
          end
        end
      endcase
    end
  end

  deq_ram #(
    .Width(deq_pkg::ValueW),
    .Depth(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(s_axis_tdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= deq_pkg::ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      if (load_now || load_read) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Count already holds the post-operation value when the read data lands
  assign count_ext = 32'(count_d);

  always_ff @(posedge clk_i) begin
    if (load_read) begin
      popped_q <= rdata;
      status_q <= deq_pkg::STATUS_OK;
      occ_q    <= count_ext[deq_pkg::OccW-1:0];
    end else if (load_now) begin
      popped_q <= popped_d;
      status_q <= status_d;
      occ_q    <= count_ext[deq_pkg::OccW-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, occ_q, popped_q};
  assign m_axis_tuser  = status_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("entry count above depth");

  a_read_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == deq_pkg::ST_READ |-> !out_valid_q && !s_axis_tready)
    else $error("output busy or input open during RAM read");

  a_underflow_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q == deq_pkg::STATUS_UNDERFLOW |-> popped_q == deq_pkg::PopEmptyValue)
    else $error("underflow result carries wrong value");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !func[1] && !full |=> count_q == $past(count_q) + CntW'(1))
    else $error("push did not grow the queue");

  a_pop_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && func[1] && !empty |=> ##1 out_valid_q && status_q == deq_pkg::STATUS_OK)
    else $error("pop result missing");

endmodule
